// ===== src/hvn_pkg.sv =====
`timescale 1ns / 1ps

package hvn_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // wide enough for any grid dimension up to 4096
    localparam int DIM_W = 13;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef logic signed [32:0] t_diff;
    typedef logic signed [29:0] t_opnd;

    function automatic t_opnd shr_trunc(input t_diff d, input logic [2:0] s);
        logic [32:0] m;
        logic [32:0] q;
        m = d[32] ? 33'(-d) : 33'(d);
        q = m >> s;
        return d[32] ? t_opnd'(-$signed({1'b0, q[28:0]})) : t_opnd'({1'b0, q[28:0]});
    endfunction

endpackage

// ===== src/heightmap_vertex_normals_core.sv =====
`timescale 1ns / 1ps
// One item at a time. A border-only item goes straight to its emit state; an interior
// normal passes through 7 row-memory reads, 12 cross-product steps, the normalize steps,
// a 32-step square root and a 3 x 16-step divider before it is emitted.
// An item with no result frees the input the next cycle; any other item holds it until
// its last result is registered at the output, which waits while i_out_stall is high.
// Reset (i_rst_n low, synchronous) clears counters, controller and output valid; grid
// size returns to 1024 x 1024. Row memories are not cleared.
module heightmap_vertex_normals_core #(
    parameter int MAX_WIDTH  = hvn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hvn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [31:0]             i_pos_x,
    input  logic signed [31:0]             i_pos_y,
    input  logic signed [31:0]             i_pos_z,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [15:0]             o_normal_x,
    output logic signed [15:0]             o_normal_y,
    output logic signed [15:0]             o_normal_z,
    output logic [9:0]                     o_vertex_column,
    output logic [9:0]                     o_vertex_row,
    output logic                           o_last_of_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hvn_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import hvn_pkg::*;

    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_MAG    = 4'd5;
    localparam logic [3:0] S_NORM   = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_SQSUM  = 4'd8;
    localparam logic [3:0] S_SQRT   = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_EMIT_I = 4'd11;
    localparam logic [3:0] S_EMIT_B = 4'd12;
    localparam logic [3:0] S_DLOAD  = 4'd13;

    logic [31:0] mem_x [0:DEPTH-1];
    logic [31:0] mem_y [0:DEPTH-1];
    logic [31:0] mem_z [0:DEPTH-1];
    logic [31:0] r_qx, r_qy, r_qz;

    logic [3:0]            r_state;
    logic [CFG_DAT_W-1:0]  r_cfg_w, r_cfg_h;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [1:0]            r_slot;

    logic [CW-1:0]         r_c;
    logic [1:0]            r_sl0, r_sl1, r_sl2;
    logic [9:0]            r_vc, r_vr;
    logic                  r_has_bor;

    logic [2:0]            r_cnt;
    logic signed [31:0]    r_p [0:7][0:2];
    t_diff                 r_da [0:3][0:2];
    t_diff                 r_db [0:3][0:2];
    logic [32:0]           r_m;
    t_opnd                 r_a [0:3][0:2];
    t_opnd                 r_b [0:3][0:2];

    logic [3:0]            r_mstep;
    logic [1:0]            r_k, r_pk;
    logic signed [59:0]    r_p1, r_p2;
    logic signed [63:0]    r_sum [0:2];
    logic [63:0]           r_mg [0:2];
    logic [2:0]            r_neg;
    logic [63:0]           r_mx;

    logic [59:0]           r_sq0, r_sq1, r_sq2;
    logic [63:0]           r_x, r_r, r_bit;
    logic [31:0]           r_l;
    logic [47:0]           r_rem, r_dsh;
    logic [15:0]           r_q;
    logic [3:0]            r_dcnt;
    logic [1:0]            r_dk;
    logic signed [15:0]    r_res [0:2];

    logic                  r_out_valid;
    logic signed [15:0]    r_nx, r_ny, r_nz;
    logic [9:0]            r_oc, r_or;
    logic                  r_olast;

    logic [DIM_W-1:0] eff_w, eff_h, w_ext, h_ext, c_ext, r_ext;
    logic             accept, out_free, emit_go, is_int, is_bor;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [1:0]       rd_slot;
    logic [CW-1:0]    rd_col;
    logic [2:0]       shamt;
    logic [63:0]      sq_trial;
    logic [47:0]      rem_sub;
    logic [15:0]      q_next, q_mag;
    logic [45:0]      num_next;

    assign w_ext = DIM_W'(r_cfg_w);
    assign h_ext = DIM_W'(r_cfg_h);
    assign eff_w = (w_ext < DIM_W'(2)) ? DIM_W'(2) :
                   (w_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_ext;
    assign eff_h = (h_ext < DIM_W'(2)) ? DIM_W'(2) :
                   (h_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_ext;
    assign c_ext = DIM_W'(r_col);
    assign r_ext = DIM_W'(r_row);

    assign is_int = (r_ext >= DIM_W'(2)) && (c_ext >= DIM_W'(1)) && (c_ext + 1'b1 < eff_w);
    assign is_bor = (r_ext == '0) || (r_ext + 1'b1 == eff_h) || (c_ext == '0)
                    || (c_ext + 1'b1 == eff_w);

    // hold the input while an item is in work or while a register write restarts the map
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_go     = out_free && ((r_state == S_EMIT_I) || (r_state == S_EMIT_B));
    assign o_cfg_ready = 1'b1;

    assign wr_addr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_col);

    // window points: rows R-2, R-1 by columns C-1, C, C+1, then row R at C-1 (row R at C is the input)
    always_comb begin
        case (r_cnt)
            3'd0, 3'd1, 3'd2: rd_slot = r_sl2;
            3'd3, 3'd4, 3'd5: rd_slot = r_sl1;
            default:          rd_slot = r_sl0;
        endcase
        case (r_cnt)
            3'd0, 3'd3, 3'd6: rd_col = r_c - 1'b1;
            3'd1, 3'd4:       rd_col = r_c;
            default:          rd_col = r_c + 1'b1;
        endcase
    end
    assign rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_x[wr_addr] <= i_pos_x;
            mem_y[wr_addr] <= i_pos_y;
            mem_z[wr_addr] <= i_pos_z;
        end
        r_qx <= mem_x[rd_addr];
        r_qy <= mem_y[rd_addr];
        r_qz <= mem_z[rd_addr];
    end

    assign shamt = r_m[32] ? 3'd4 : r_m[31] ? 3'd3 : r_m[30] ? 3'd2 : r_m[29] ? 3'd1 : 3'd0;

    assign sq_trial = r_r + r_bit;
    assign rem_sub  = r_rem - r_dsh;
    assign q_next   = {r_q[14:0], (r_rem >= r_dsh)};
    assign q_mag    = (q_next > 16'(ONE_Q14)) ? 16'(ONE_Q14) : q_next;
    assign num_next = {r_mg[1][29:0], 15'd0} + 46'(r_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= CFG_DAT_W'(1024);
            r_cfg_h     <= CFG_DAT_W'(1024);
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_slot  <= '0;
                end else if (i_cfg_index == CFG_GRID_HEIGHT) begin
                    r_cfg_h <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_slot  <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_c       <= r_col;
                        r_sl0     <= r_slot;
                        r_sl1     <= (r_slot == 2'd0) ? 2'd2 : r_slot - 1'b1;
                        r_sl2     <= (r_slot == 2'd2) ? 2'd0 : r_slot + 1'b1;
                        r_vc      <= c_ext[9:0];
                        r_vr      <= r_ext[9:0];
                        r_has_bor <= is_bor;
                        r_p[7][0] <= i_pos_x;
                        r_p[7][1] <= i_pos_y;
                        r_p[7][2] <= i_pos_z;
                        r_cnt     <= '0;
                        if (c_ext + 1'b1 >= eff_w) begin
                            r_col <= '0;
                            if (r_ext + 1'b1 >= eff_h) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= r_row + 1'b1;
                                r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (is_int) begin
                            r_state <= S_READ;
                        end else if (is_bor) begin
                            r_state <= S_EMIT_B;
                        end
                    end
                end
                S_READ: begin
                    if (r_cnt != 3'd0) begin
                        r_p[r_cnt - 1'b1][0] <= r_qx;
                        r_p[r_cnt - 1'b1][1] <= r_qy;
                        r_p[r_cnt - 1'b1][2] <= r_qz;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    logic [32:0] acc;
                    acc = '0;
                    for (int f = 0; f < 4; f++) begin
                        for (int k = 0; k < 3; k++) begin
                            t_diff da, db;
                            da = {r_p[f + f/2][k][31], r_p[f + f/2][k]}
                                 - {r_p[f + f/2 + 3][k][31], r_p[f + f/2 + 3][k]};
                            db = {r_p[f + f/2 + 3][k][31], r_p[f + f/2 + 3][k]}
                                 - {r_p[f + f/2 + 1][k][31], r_p[f + f/2 + 1][k]};
                            r_da[f][k] <= da;
                            r_db[f][k] <= db;
                            acc = acc | (da[32] ? 33'(-da) : 33'(da))
                                      | (db[32] ? 33'(-db) : 33'(db));
                        end
                    end
                    r_m     <= acc;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    for (int f = 0; f < 4; f++) begin
                        for (int k = 0; k < 3; k++) begin
                            r_a[f][k] <= shr_trunc(r_da[f][k], shamt);
                            r_b[f][k] <= shr_trunc(r_db[f][k], shamt);
                        end
                    end
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= '0;
                    end
                    r_mstep <= '0;
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // face 0 rotates its components; after the third, the next face moves in
                    if (r_mstep != 4'd12) begin
                        r_p1 <= r_a[0][1] * r_b[0][2];
                        r_p2 <= r_a[0][2] * r_b[0][1];
                        r_pk <= r_k;
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            for (int f = 0; f < 3; f++) begin
                                r_a[f] <= r_a[f + 1];
                                r_b[f] <= r_b[f + 1];
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_a[0][0] <= r_a[0][1];
                            r_a[0][1] <= r_a[0][2];
                            r_a[0][2] <= r_a[0][0];
                            r_b[0][0] <= r_b[0][1];
                            r_b[0][1] <= r_b[0][2];
                            r_b[0][2] <= r_b[0][0];
                        end
                    end
                    if (r_mstep != 4'd0) begin
                        r_sum[r_pk] <= r_sum[r_pk] + 64'(r_p1) - 64'(r_p2);
                    end
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 4'd12) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    logic [63:0] m0, m1, m2, mx;
                    m0 = r_sum[0][63] ? 64'(-r_sum[0]) : 64'(r_sum[0]);
                    m1 = r_sum[1][63] ? 64'(-r_sum[1]) : 64'(r_sum[1]);
                    m2 = r_sum[2][63] ? 64'(-r_sum[2]) : 64'(r_sum[2]);
                    mx = m0;
                    if (m1 > mx) mx = m1;
                    if (m2 > mx) mx = m2;
                    r_mg[0] <= m0;
                    r_mg[1] <= m1;
                    r_mg[2] <= m2;
                    r_mx    <= mx;
                    r_neg   <= {r_sum[2][63], r_sum[1][63], r_sum[0][63]};
                    if (mx == '0) begin
                        r_res[0] <= '0;
                        r_res[1] <= ONE_Q14;
                        r_res[2] <= '0;
                        r_state  <= S_EMIT_I;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (r_mx >= 64'd1 << 37) begin
                        r_mx <= r_mx >> 8;
                        for (int k = 0; k < 3; k++) r_mg[k] <= r_mg[k] >> 8;
                    end else if (r_mx >= 64'd1 << 30) begin
                        r_mx <= r_mx >> 1;
                        for (int k = 0; k < 3; k++) r_mg[k] <= r_mg[k] >> 1;
                    end else if (r_mx < 64'd1 << 21) begin
                        r_mx <= r_mx << 8;
                        for (int k = 0; k < 3; k++) r_mg[k] <= r_mg[k] << 8;
                    end else if (r_mx < 64'd1 << 29) begin
                        r_mx <= r_mx << 1;
                        for (int k = 0; k < 3; k++) r_mg[k] <= r_mg[k] << 1;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq0   <= r_mg[0][29:0] * r_mg[0][29:0];
                    r_sq1   <= r_mg[1][29:0] * r_mg[1][29:0];
                    r_sq2   <= r_mg[2][29:0] * r_mg[2][29:0];
                    r_state <= S_SQSUM;
                end
                S_SQSUM: begin
                    r_x     <= 64'(r_sq0) + 64'(r_sq1) + 64'(r_sq2);
                    r_r     <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_x >= sq_trial) begin
                        r_x <= r_x - sq_trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    // load numerator and aligned divisor of the first component
                    r_l     <= r_r[31:0];
                    r_rem   <= 48'({r_mg[0][29:0], 15'd0}) + 48'(r_r[31:0]);
                    r_dsh   <= {r_r[31:0], 16'd0};
                    r_q     <= '0;
                    r_dk    <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == 4'd15) begin
                        r_res[r_dk] <= r_neg[0] ? -$signed(q_mag) : $signed(q_mag);
                        r_neg       <= {1'b0, r_neg[2:1]};
                        r_mg[0]     <= r_mg[1];
                        r_mg[1]     <= r_mg[2];
                        r_rem       <= 48'(num_next);
                        r_dsh       <= {r_l, 16'd0};
                        r_q         <= '0;
                        r_dk        <= r_dk + 1'b1;
                        if (r_dk == 2'd2) begin
                            r_state <= S_EMIT_I;
                        end
                    end else begin
                        if (r_rem >= r_dsh) begin
                            r_rem <= rem_sub;
                        end
                        r_dsh <= r_dsh >> 1;
                        r_q   <= q_next;
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                end
                S_EMIT_I: begin
                    if (out_free) begin
                        r_nx        <= r_res[0];
                        r_ny        <= r_res[1];
                        r_nz        <= r_res[2];
                        r_oc        <= r_vc;
                        r_or        <= r_vr - 1'b1;
                        r_olast     <= !r_has_bor;
                        r_state     <= r_has_bor ? S_EMIT_B : S_IDLE;
                    end
                end
                S_EMIT_B: begin
                    if (out_free) begin
                        r_nx        <= '0;
                        r_ny        <= ONE_Q14;
                        r_nz        <= '0;
                        r_oc        <= r_vc;
                        r_or        <= r_vr;
                        r_olast     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_normal_x      = r_nx;
    assign o_normal_y      = r_ny;
    assign o_normal_z      = r_nz;
    assign o_vertex_column = r_oc;
    assign o_vertex_row    = r_or;
    assign o_last_of_item  = r_olast;

endmodule
